// ===== hw/rtl/kf2_pkg.sv =====
package kf2_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int CFG_W   = 31;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;

  localparam logic [1:0] REG_PROCESS_NOISE    = 2'd0;
  localparam logic [1:0] REG_MEAS_NOISE       = 2'd1;
  localparam logic [1:0] REG_PREDICT_INTERVAL = 2'd2;

  localparam logic [CFG_W-1:0] PROCESS_NOISE_RST    = 31'd6554;
  localparam logic [CFG_W-1:0] MEAS_NOISE_RST       = 31'd65536;
  localparam logic [CFG_W-1:0] PREDICT_INTERVAL_RST = 31'd3277;

  localparam logic CMD_UPDATE  = 1'b0;
  localparam logic CMD_PREDICT = 1'b1;

  localparam logic [3:0] STEP_POS_PRED = 4'd0;
  localparam logic [3:0] STEP_FP00     = 4'd1;
  localparam logic [3:0] STEP_FP01     = 4'd2;
  localparam logic [3:0] STEP_P00_PRED = 4'd3;
  localparam logic [3:0] STEP_P10_PRED = 4'd4;
  localparam logic [3:0] STEP_P11_PRED = 4'd5;
  localparam logic [3:0] STEP_INNOV    = 4'd6;
  localparam logic [3:0] STEP_POS_UPD  = 4'd7;
  localparam logic [3:0] STEP_VEL_UPD  = 4'd8;
  localparam logic [3:0] STEP_P11_UPD  = 4'd9;
  localparam logic [3:0] STEP_P10_UPD  = 4'd10;
  localparam logic [3:0] STEP_P01_UPD  = 4'd11;
  localparam logic [3:0] STEP_P00_UPD  = 4'd12;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_ACC   = 6'b000100,
    S_DLOAD = 6'b001000,
    S_DIV   = 6'b010000,
    S_DEND  = 6'b100000
  } state_t;

endpackage

// ===== hw/rtl/kalman_filter_2state_cv_unit.sv =====
// Two-state constant-velocity Kalman tracker, signed fixed point with
// FRAC_BITS fraction bits.
// Input channel (in_valid/in_ready): cmd, measurement, time_step. cmd high
// runs a predict step over predict_interval; cmd low predicts over time_step
// and corrects with the measured position.
// Output channel (out_valid/out_ready): position, velocity and
// position_variance after the item, one beat per input beat.
// One item at a time: in_ready is high only while the sequencer is idle.
// All arithmetic goes through one 32x32 multiplier (a multiply-add runs
// through S_MUL and S_ACC) and a one-bit-per-cycle restoring divider.
// The two gain divisions of an update are skipped when the innovation
// variance is zero.
// A stalled result holds in the output register; a following item is
// accepted and computed, and waits at its end until that register frees.
// Reset (synchronous): zero state, identity covariance, register defaults.
// Registers over APB at 0x0 process_noise, 0x4 meas_noise,
// 0x8 predict_interval; write only while idle.
module kalman_filter_2state_cv_unit
  import kf2_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     cmd,
  input  logic signed [31:0]       measurement,
  input  logic        [30:0]       time_step,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [31:0]       position,
  output logic signed [31:0]       velocity,
  output logic signed [31:0]       position_variance,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic        [ADDR_W-1:0] paddr,
  input  logic        [DATA_W-1:0] pwdata,
  output logic        [DATA_W-1:0] prdata,
  output logic                     pready
);

  localparam int DIV_N = 32 + FRAC_BITS;
  localparam int CNT_W = $clog2(DIV_N + 1);
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] SMAX = 32'sh7fffffff;
  localparam logic signed [31:0] SMIN = 32'sh80000000;

  logic [CFG_W-1:0] process_noise, meas_noise, predict_interval;

  state_t state;
  logic [3:0] step;
  logic       cmd_r;
  logic signed [31:0] z_r, dt;
  logic signed [31:0] pos, vel, p00, p01, p10, p11, t0, k0, k1;
  logic signed [63:0] prod;

  logic              div_sel, div_neg;
  logic [DIV_N-1:0]  dvd, quo;
  logic [32:0]       rem, den;
  logic [CNT_W-1:0]  cnt;

  // register port
  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      REG_PROCESS_NOISE:    prdata = {1'b0, process_noise};
      REG_MEAS_NOISE:       prdata = {1'b0, meas_noise};
      REG_PREDICT_INTERVAL: prdata = {1'b0, predict_interval};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise    <= PROCESS_NOISE_RST;
      meas_noise       <= MEAS_NOISE_RST;
      predict_interval <= PREDICT_INTERVAL_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_PROCESS_NOISE:    process_noise    <= pwdata[CFG_W-1:0];
        REG_MEAS_NOISE:       meas_noise       <= pwdata[CFG_W-1:0];
        REG_PREDICT_INTERVAL: predict_interval <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // operand select
  logic signed [31:0] m1, m2;
  logic signed [32:0] a1, a2;
  logic               neg;
  logic signed [32:0] qx;
  assign qx = {2'b00, process_noise};

  always_comb begin
    m1  = '0;
    m2  = '0;
    a1  = '0;
    a2  = '0;
    neg = 1'b0;
    case (step)
      STEP_POS_PRED: begin m1 = dt; m2 = vel; a1 = {pos[31], pos}; end
      STEP_FP00:     begin m1 = dt; m2 = p10; a1 = {p00[31], p00}; end
      STEP_FP01:     begin m1 = dt; m2 = p11; a1 = {p01[31], p01}; end
      STEP_P00_PRED: begin m1 = dt; m2 = p01; a1 = {t0[31], t0}; a2 = qx; end
      STEP_P10_PRED: begin m1 = dt; m2 = p11; a1 = {p10[31], p10}; end
      STEP_P11_PRED: begin a1 = {p11[31], p11}; a2 = qx; end
      STEP_INNOV:    begin a1 = {z_r[31], z_r}; a2 = -{pos[31], pos}; end
      STEP_POS_UPD:  begin m1 = k0; m2 = t0; a1 = {pos[31], pos}; end
      STEP_VEL_UPD:  begin m1 = k1; m2 = t0; a1 = {vel[31], vel}; end
      STEP_P11_UPD:  begin m1 = k1; m2 = p01; a1 = {p11[31], p11}; neg = 1'b1; end
      STEP_P10_UPD:  begin m1 = k1; m2 = p00; a1 = {p10[31], p10}; neg = 1'b1; end
      STEP_P01_UPD:  begin m1 = k0; m2 = p01; a1 = {p01[31], p01}; neg = 1'b1; end
      STEP_P00_UPD:  begin m1 = k0; m2 = p00; a1 = {p00[31], p00}; neg = 1'b1; end
      default: ;
    endcase
  end

  // rounded product added to or taken from the addends, saturated
  logic signed [63:0] rnd;
  logic signed [65:0] term, sum;
  logic signed [31:0] acc;
  assign rnd  = (prod + HALF) >>> FRAC_BITS;
  assign term = neg ? -{{2{rnd[63]}}, rnd} : {{2{rnd[63]}}, rnd};
  assign sum  = term + {{33{a1[32]}}, a1} + {{33{a2[32]}}, a2};
  always_comb begin
    if (sum > 66'sh7fffffff)        acc = SMAX;
    else if (sum < -66'sh80000000)  acc = SMIN;
    else                            acc = sum[31:0];
  end

  // divider setup and finish
  logic signed [32:0] s_val;
  logic signed [31:0] div_src;
  logic        [31:0] src_mag;
  logic        [32:0] s_mag;
  logic        [33:0] rem_sh;
  logic signed [31:0] gain;
  assign s_val   = {p00[31], p00} + {2'b00, meas_noise};
  assign div_src = div_sel ? p10 : p00;
  assign src_mag = div_src[31] ? 32'(-div_src) : div_src;
  assign s_mag   = s_val[32] ? 33'(-s_val) : s_val;
  assign rem_sh  = {rem, dvd[DIV_N-1]};
  always_comb begin
    if (!div_neg) begin
      gain = (quo[DIV_N-1:31] != '0) ? SMAX : quo[31:0];
    end else if ((quo[DIV_N-1:32] != '0) || (quo[31] && (quo[30:0] != '0))) begin
      gain = SMIN;
    end else begin
      gain = 32'(-quo[31:0]);
    end
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= STEP_POS_PRED;
      out_valid <= 1'b0;
      div_sel   <= 1'b0;
      pos       <= '0;
      vel       <= '0;
      p00       <= ONE;
      p01       <= '0;
      p10       <= '0;
      p11       <= ONE;
    end else begin
      if (out_valid && out_ready && state != S_DEND) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r <= cmd;
            z_r   <= measurement;
            dt    <= (cmd == CMD_PREDICT) ? {1'b0, predict_interval} : {1'b0, time_step};
            step  <= STEP_POS_PRED;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= m1 * m2;
          state <= S_ACC;
        end
        S_ACC: begin
          case (step)
            STEP_POS_PRED, STEP_POS_UPD: pos <= acc;
            STEP_FP00, STEP_INNOV:       t0  <= acc;
            STEP_FP01, STEP_P01_UPD:     p01 <= acc;
            STEP_P00_PRED, STEP_P00_UPD: p00 <= acc;
            STEP_P10_PRED, STEP_P10_UPD: p10 <= acc;
            STEP_P11_PRED, STEP_P11_UPD: p11 <= acc;
            STEP_VEL_UPD:                vel <= acc;
            default: ;
          endcase
          if ((step == STEP_P11_PRED && cmd_r == CMD_PREDICT) || step == STEP_P00_UPD) begin
            state <= S_DEND;
          end else if (step == STEP_INNOV) begin
            div_sel <= 1'b0;
            step    <= step + 4'd1;
            state   <= S_DLOAD;
          end else begin
            step  <= step + 4'd1;
            state <= S_MUL;
          end
        end
        S_DLOAD: begin
          if (s_val == '0) begin
            k0    <= '0;
            k1    <= '0;
            state <= S_MUL;
          end else begin
            dvd     <= {src_mag, {FRAC_BITS{1'b0}}};
            den     <= s_mag;
            rem     <= '0;
            quo     <= '0;
            div_neg <= div_src[31] ^ s_val[32];
            cnt     <= CNT_W'(DIV_N);
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt == '0) begin
            if (div_sel) begin
              k1    <= gain;
              state <= S_MUL;
            end else begin
              k0      <= gain;
              div_sel <= 1'b1;
              state   <= S_DLOAD;
            end
          end else begin
            if (rem_sh >= {1'b0, den}) begin
              rem <= 33'(rem_sh - {1'b0, den});
              quo <= {quo[DIV_N-2:0], 1'b1};
            end else begin
              rem <= rem_sh[32:0];
              quo <= {quo[DIV_N-2:0], 1'b0};
            end
            dvd <= dvd << 1;
            cnt <= cnt - CNT_W'(1);
          end
        end
        S_DEND: begin
          if (!out_valid || out_ready) begin
            position          <= pos;
            velocity          <= vel;
            position_variance <= p00;
            out_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state not one-hot");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat accepted while busy");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(position) && $stable(velocity)
      && $stable(position_variance))
    else $error("stalled result dropped");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= STEP_P00_UPD)
    else $error("step beyond last operation");
  a_predict_ends: assert property (@(posedge clk) disable iff (rst)
    state == S_DLOAD |-> cmd_r == CMD_UPDATE)
    else $error("gain division on a predict-only beat");

endmodule
